FILE: rtl/core/piecewise_linear_curve_lookup_assert.svh
// ----------------------------------------------------------------------------
// piecewise linear curve lookup assertion macros
// shared concurrent assertion forms, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define PLCL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg
// widths, codes and types shared by the curve lookup modules
// ----------------------------------------------------------------------------
`default_nettype none

package plcl_pkg;

  localparam int IDX_W    = 4;
  localparam int POINTS   = 1 << IDX_W;
  localparam int TIME_W   = 24;
  localparam int FACTOR_W = 32;
  localparam int CFG_W    = 5;
  localparam int PROD_W   = TIME_W + FACTOR_W;
  localparam int CNT_W    = $clog2(FACTOR_W);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REGION_INTERP = 2'd0,
    REGION_FIRST  = 2'd1,
    REGION_LAST   = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_INTERP
  } state_e;

  typedef enum logic [1:0] {
    I_IDLE,
    I_MUL,
    I_DIV,
    I_FIN
  } interp_state_e;

  typedef struct packed {
    logic [TIME_W-1:0]   t;
    logic [TIME_W-1:0]   x0;
    logic [TIME_W-1:0]   x1;
    logic [FACTOR_W-1:0] y0;
    logic [FACTOR_W-1:0] y1;
  } interp_req_t;

  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] factor;
  } interp_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/piecewise_linear_curve_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup
// discount curve lookup with linear interpolation and clamping at both ends
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low. A
// write (mode 0) stores one point in the accept cycle and gives no result;
// busy stays low, so the next transaction can follow at once. A query
// (mode 1) raises busy until its result is out. The result shows on
// factor_o and region_o for exactly one cycle with done_o high; the receiver
// cannot hold it off, and busy falls in that same cycle. A query clamped at
// the first point completes from state S_FIRST, one clamped at the last
// point from S_LAST. An interpolated query scans the table entries one by
// one through the single read port up to the upper point found, then runs
// one multiply and a 32-step shift-subtract divider. Times are unsigned
// Q8.16, factors unsigned Q2.30; the quotient truncates toward zero.
// cfg_wdata_i sets the number of points in use (zero counts as one, values
// above the table size as the table size); write it only while idle.
// Table entries that were never written read as undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_curve_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          mode_i,
  input  wire logic [plcl_pkg::IDX_W-1:0]    point_index_i,
  input  wire logic [plcl_pkg::TIME_W-1:0]   point_time_i,
  input  wire logic [plcl_pkg::FACTOR_W-1:0] point_factor_i,
  input  wire logic [plcl_pkg::TIME_W-1:0]   query_time_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [plcl_pkg::CFG_W-1:0]    cfg_wdata_i,
  output      logic                          done_o,
  output      logic [plcl_pkg::FACTOR_W-1:0] factor_o,
  output      logic [1:0]                    region_o
);
  import plcl_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    points_in_use_q;
  logic [CFG_W-1:0]    points_m1;
  logic [IDX_W-1:0]    last_w;

  logic [TIME_W-1:0]   t_q;
  logic [IDX_W-1:0]    last_q;
  logic [IDX_W-1:0]    idx_q;
  logic [TIME_W-1:0]   x0_q;
  logic [FACTOR_W-1:0] y0_q;

  logic                accept;
  logic                wr_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [TIME_W-1:0]   rd_time;
  logic [FACTOR_W-1:0] rd_factor;

  logic                interp_start;
  interp_req_t         interp_req;
  interp_rsp_t         interp_rsp;

  // result outputs
  logic                done_q, done_d;
  logic [FACTOR_W-1:0] factor_q, factor_d;
  region_e             region_q, region_d;

  // scan control
  logic                scan_more;
  logic                load_lower;

  assign accept = start && !busy;
  assign wr_en  = accept && (mode_i == MODE_WRITE);
  assign busy   = state_q != S_IDLE;

  // active point count clamped to 1 .. POINTS, kept as the last index
  assign points_m1 = points_in_use_q - 1'b1;
  assign last_w    = (points_in_use_q == '0)             ? '0 :
                     (points_in_use_q > CFG_W'(POINTS))  ? IDX_W'(POINTS - 1) :
                                                           points_m1[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_in_use_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      points_in_use_q <= cfg_wdata_i;
    end
  end

  plcl_table u_table (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (point_index_i),
    .wtime_i   (point_time_i),
    .wfactor_i (point_factor_i),
    .raddr_i   (rd_addr),
    .rtime_o   (rd_time),
    .rfactor_o (rd_factor)
  );

  // upper point is the entry on the read port when the scan stops
  assign interp_req.t  = t_q;
  assign interp_req.x0 = x0_q;
  assign interp_req.x1 = rd_time;
  assign interp_req.y0 = y0_q;
  assign interp_req.y1 = rd_factor;

  plcl_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (interp_start),
    .req_i   (interp_req),
    .rsp_o   (interp_rsp)
  );

  // keep walking while below the last index and the entry is still below t
  assign scan_more = (idx_q < last_q) && (rd_time < t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    factor_d     = rd_factor;
    region_d     = REGION_INTERP;
    rd_addr      = '0;
    interp_start = 1'b0;
    load_lower   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // entry zero is read while waiting
        if (accept && (mode_i == MODE_QUERY)) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        rd_addr = last_q;
        if (t_q <= rd_time) begin
          done_d   = 1'b1;
          region_d = REGION_FIRST;
          state_d  = S_IDLE;
        end else begin
          load_lower = 1'b1;
          state_d    = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr = IDX_W'(1);
        if (t_q >= rd_time) begin
          done_d   = 1'b1;
          region_d = REGION_LAST;
          state_d  = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = idx_q + 1'b1;
        if (scan_more) begin
          load_lower = 1'b1;
        end else begin
          interp_start = 1'b1;
          state_d      = S_INTERP;
        end
      end
      S_INTERP: begin
        if (interp_rsp.done) begin
          done_d   = 1'b1;
          factor_d = interp_rsp.factor;
          region_d = REGION_INTERP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // query context and lower point, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == MODE_QUERY)) begin
      t_q    <= query_time_i;
      last_q <= last_w;
    end
    if (load_lower) begin
      x0_q <= rd_time;
      y0_q <= rd_factor;
    end
    if (state_q == S_LAST) begin
      idx_q <= IDX_W'(1);
    end else if ((state_q == S_SCAN) && scan_more) begin
      idx_q <= idx_q + 1'b1;
    end
    if (done_d) begin
      factor_q <= factor_d;
      region_q <= region_d;
    end
  end

  assign done_o   = done_q;
  assign factor_o = factor_q;
  assign region_o = region_q;

`include "piecewise_linear_curve_lookup_assert.svh"

  `PLCL_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `PLCL_ASSERT_NEXT(a_query_busy, start && !busy && (mode_i == MODE_QUERY), busy, "query not taken")
  `PLCL_ASSERT_IMPL(a_scan_index, state_q == S_SCAN, (idx_q != '0) && (idx_q <= last_q), "scan index out of range")
  `PLCL_ASSERT_IMPL(a_write_idle, start && !busy && (mode_i == MODE_WRITE), !done_d, "write raised a result")

endmodule

`default_nettype wire

FILE: rtl/core/plcl_table.sv
// ----------------------------------------------------------------------------
// plcl_table
// curve point storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_table (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [plcl_pkg::IDX_W-1:0]    waddr_i,
  input  wire logic [plcl_pkg::TIME_W-1:0]   wtime_i,
  input  wire logic [plcl_pkg::FACTOR_W-1:0] wfactor_i,
  input  wire logic [plcl_pkg::IDX_W-1:0]    raddr_i,
  output      logic [plcl_pkg::TIME_W-1:0]   rtime_o,
  output      logic [plcl_pkg::FACTOR_W-1:0] rfactor_o
);
  import plcl_pkg::*;

  logic [TIME_W-1:0]   time_mem   [POINTS];
  logic [FACTOR_W-1:0] factor_mem [POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]   <= wtime_i;
      factor_mem[waddr_i] <= wfactor_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rtime_o   <= time_mem[raddr_i];
    rfactor_o <= factor_mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/plcl_interp.sv
// ----------------------------------------------------------------------------
// plcl_interp
// interpolation unit: one multiply, then a shift-subtract divider stepped
// one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_interp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire plcl_pkg::interp_req_t req_i,
  output      plcl_pkg::interp_rsp_t rsp_o
);
  import plcl_pkg::*;

  interp_state_e state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [TIME_W-1:0]   dt_q, span_q, rem_q;
  logic [FACTOR_W-1:0] mag_q, y0_q, quo_q;
  logic                neg_q;

  logic [PROD_W-1:0]   prod;
  logic [TIME_W:0]     partial;
  logic [TIME_W:0]     diff;
  logic                ge;
  logic [FACTOR_W+1:0] res;

  assign prod    = PROD_W'(mag_q) * PROD_W'(dt_q);
  assign partial = {rem_q, quo_q[FACTOR_W-1]};
  assign ge      = partial >= {1'b0, span_q};
  assign diff    = partial - {1'b0, span_q};

  // result stays between y0 and y1, saturation kept as a guard
  always_comb begin
    if (neg_q) begin
      res = {2'b00, y0_q} - {2'b00, quo_q};
    end else begin
      res = {2'b00, y0_q} + {2'b00, quo_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rsp_o.done   = 1'b0;
    rsp_o.factor = '0;
    unique case (state_q)
      I_IDLE: begin
        if (start_i) begin
          state_d = I_MUL;
        end
      end
      I_MUL: begin
        cnt_d   = CNT_W'(FACTOR_W - 1);
        state_d = I_DIV;
      end
      I_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = I_FIN;
        end
      end
      I_FIN: begin
        rsp_o.done = 1'b1;
        if (res[FACTOR_W+1]) begin
          rsp_o.factor = '0;
        end else if (res[FACTOR_W]) begin
          rsp_o.factor = '1;
        end else begin
          rsp_o.factor = res[FACTOR_W-1:0];
        end
        state_d = I_IDLE;
      end
      default: state_d = I_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      I_IDLE: begin
        if (start_i) begin
          dt_q   <= req_i.t - req_i.x0;
          span_q <= req_i.x1 - req_i.x0;
          y0_q   <= req_i.y0;
          neg_q  <= req_i.y1 < req_i.y0;
          mag_q  <= (req_i.y1 < req_i.y0) ? req_i.y0 - req_i.y1 : req_i.y1 - req_i.y0;
        end
      end
      I_MUL: begin
        // upper product bits start as the remainder, below the span
        rem_q <= prod[PROD_W-1:FACTOR_W];
        quo_q <= prod[FACTOR_W-1:0];
      end
      I_DIV: begin
        rem_q <= ge ? diff[TIME_W-1:0] : partial[TIME_W-1:0];
        quo_q <= {quo_q[FACTOR_W-2:0], ge};
      end
      default: ;
    endcase
  end

`include "piecewise_linear_curve_lookup_assert.svh"

  `PLCL_ASSERT_IMPL(a_start_when_idle, start_i, state_q == I_IDLE, "start while unit busy")
  `PLCL_ASSERT_IMPL(a_rem_below_span, state_q == I_DIV, rem_q < span_q, "remainder not below span")
  `PLCL_ASSERT_NEXT(a_fin_to_idle, state_q == I_FIN, state_q == I_IDLE, "unit did not return idle")

endmodule

`default_nettype wire

FILE: sim/piecewise_linear_curve_lookup_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_tb
// self-checking bench for the discount curve lookup: a predictor tracks the
// point table and the points-in-use register from the transactions seen on
// the ports, and every result is compared against it field by field
// ----------------------------------------------------------------------------

module piecewise_linear_curve_lookup_tb;
  import plcl_pkg::*;

  // run limits, all in clock cycles
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 80;
  localparam int MAX_GAP       = 12;

  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    region_e             region;
  } curve_result_t;

  // dut ports, all inputs known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                mode_i         = MODE_WRITE;
  logic [IDX_W-1:0]    point_index_i  = '0;
  logic [TIME_W-1:0]   point_time_i   = '0;
  logic [FACTOR_W-1:0] point_factor_i = '0;
  logic [TIME_W-1:0]   query_time_i   = '0;
  logic                cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i    = '0;
  logic                done_o;
  logic [FACTOR_W-1:0] factor_o;
  logic [1:0]          region_o;

  // predictor state: its own copy of the point table and the register
  logic [TIME_W-1:0]   curve_time   [POINTS];
  logic [FACTOR_W-1:0] curve_factor [POINTS];
  logic [CFG_W-1:0]    curve_points_cfg = 5'd1;

  curve_result_t pending_results[$];
  int error_count     = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 0;

  piecewise_linear_curve_lookup u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .point_index_i  (point_index_i),
    .point_time_i   (point_time_i),
    .point_factor_i (point_factor_i),
    .query_time_i   (query_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .factor_o       (factor_o),
    .region_o       (region_o)
  );

  // 4 time unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero counts as one point, anything past the table as the whole table
  function automatic int active_count(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (cfg > POINTS) return POINTS;
    return int'(cfg);
  endfunction

  // y0 + trunc((t - x0) * (y1 - y0) / (x1 - x0)), saturated to the factor range
  function automatic logic [FACTOR_W-1:0] blend_factor(
    input logic [TIME_W-1:0]   t,
    input logic [TIME_W-1:0]   x0,
    input logic [TIME_W-1:0]   x1,
    input logic [FACTOR_W-1:0] y0,
    input logic [FACTOR_W-1:0] y1
  );
    longint unsigned dt, span, slope_mag, step;
    longint          blended;
    dt   = t - x0;
    span = x1 - x0;
    if (span == 0) return y0;
    // magnitude first so the truncation goes toward zero for both slopes
    if (y1 >= y0) begin
      slope_mag = y1 - y0;
      step      = (slope_mag * dt) / span;
      blended   = longint'(y0) + longint'(step);
    end else begin
      slope_mag = y0 - y1;
      step      = (slope_mag * dt) / span;
      blended   = longint'(y0) - longint'(step);
    end
    if (blended < 0) return '0;
    if (blended > longint'(FACTOR_MAX)) return FACTOR_MAX;
    return blended[FACTOR_W-1:0];
  endfunction

  function automatic curve_result_t predict_curve(input logic [TIME_W-1:0] t);
    int            top, k;
    curve_result_t r;
    top = active_count(curve_points_cfg) - 1;
    if (t <= curve_time[0]) begin
      r.factor = curve_factor[0];
      r.region = REGION_FIRST;
    end else if (t >= curve_time[top]) begin
      r.factor = curve_factor[top];
      r.region = REGION_LAST;
    end else begin
      // first point from index one up that is at or above t; the scan stops
      // at the last point in use, which is above t here
      k = 1;
      while (k < top && curve_time[k] < t) k++;
      r.factor = blend_factor(t, curve_time[k-1], curve_time[k],
                              curve_factor[k-1], curve_factor[k]);
      r.region = REGION_INTERP;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // port monitor: checks results, then tracks register writes and accepted
  // transactions; all sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    curve_result_t want;
    if (rst_ni) begin
      // a result leaving in the same cycle as a new query is accepted is
      // checked first, so it pops the older expectation
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: factor %h, region %0d",
                 factor_o, region_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (factor_o !== want.factor) begin
            $error("factor: expected %h, actual %h", want.factor, factor_o);
            error_count++;
          end
          if (region_o !== want.region) begin
            $error("region: expected %0d, actual %0d", want.region, region_o);
            error_count++;
          end
        end
      end
      if (cfg_we_i) curve_points_cfg = cfg_wdata_i;
      if (start && !busy) begin
        if (mode_i == MODE_WRITE) begin
          curve_time[point_index_i]   = point_time_i;
          curve_factor[point_index_i] = point_factor_i;
        end else begin
          pending_results.push_back(predict_curve(query_time_i));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver side; everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // one transaction, then a random idle stretch; start stays high when the
  // next transaction follows at once
  task automatic send_item(
    input logic                m,
    input logic [IDX_W-1:0]    idx,
    input logic [TIME_W-1:0]   pt,
    input logic [FACTOR_W-1:0] pf,
    input logic [TIME_W-1:0]   qt
  );
    int gap;
    @(negedge clk_i);
    start          <= 1'b1;
    mode_i         <= m;
    point_index_i  <= idx;
    point_time_i   <= pt;
    point_factor_i <= pf;
    query_time_i   <= qt;
    // busy only moves on a rising edge, so reading it here is race free
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // unused fields carry random data so the block is seen to ignore them
  task automatic write_point(
    input logic [IDX_W-1:0]    idx,
    input logic [TIME_W-1:0]   pt,
    input logic [FACTOR_W-1:0] pf
  );
    send_item(MODE_WRITE, idx, pt, pf, TIME_W'($urandom()));
  endtask

  task automatic query_curve(input logic [TIME_W-1:0] qt);
    send_item(MODE_QUERY, IDX_W'($urandom()), TIME_W'($urandom()), $urandom(), qt);
  endtask

  // wait for every outstanding query, then a few quiet cycles; a write has
  // no result but completes in its accept cycle
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_points(input logic [CFG_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every slot gets written before any query, so no query can touch an
  // undefined entry; maturities run evenly from zero to full scale and the
  // factors swing between the extremes for the steepest slopes
  task automatic test_fill_table();
    int i;
    for (i = 0; i < POINTS; i++)
      write_point(IDX_W'(i), TIME_W'(i * 32'h11_1111),
                  i[0] ? FACTOR_MAX - FACTOR_W'(i) : FACTOR_W'(i));
  endtask

  // both clamps, just inside each end, exact points and a mid-segment point
  task automatic test_curve_corners();
    set_points(CFG_W'(POINTS));
    query_curve('0);
    query_curve(TIME_MAX);
    query_curve(24'h00_0001);
    query_curve(TIME_MAX - 1'b1);
    query_curve(24'h11_1111);
    query_curve(24'h88_8888);
    query_curve(24'h8F_FFFF);
  endtask

  // zero points in use behaves as one, over the table size as the table
  task automatic test_point_count();
    logic [CFG_W-1:0] counts [4] = '{5'd0, 5'd31, 5'd2, 5'd1};
    int i;
    for (i = 0; i < 4; i++) begin
      set_points(counts[i]);
      query_curve(24'h00_0005);
      query_curve(24'h20_0000);
    end
  endtask

  // an out-of-order maturity and a repeated maturity inside the table
  task automatic test_unsorted_table();
    set_points(CFG_W'(POINTS));
    write_point(4'd3, 24'h05_0000, 32'h4000_0000);
    query_curve(24'h06_0000);
    query_curve(24'h30_0000);
    write_point(4'd5, 24'h44_4444, FACTOR_MAX);
    query_curve(24'h44_4444);
    query_curve(24'h44_4445);
    write_point(4'd3, 24'h33_3333, FACTOR_MAX - 3);
    write_point(4'd5, 24'h55_5555, FACTOR_MAX - 5);
  endtask

  // random curves: set a point count, load that many points (mostly in
  // ascending order), then query them, mostly within the curve, with some
  // stray writes that break the order
  task automatic test_random_curves(input int idle_pct, input int item_budget);
    logic [TIME_W-1:0]   tt [POINTS];
    logic [FACTOR_W-1:0] ff [POINTS];
    logic [TIME_W-1:0]   lo, hi, qt;
    logic [CFG_W-1:0]    cfg_value;
    int                  sent, n, i, q, nq, pick, slot, t_acc, step_max;
    bit                  shuffled;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < item_budget) begin
      case ($urandom_range(9))
        0:       cfg_value = '0;
        1:       cfg_value = CFG_W'($urandom_range(31, POINTS + 1));
        2:       cfg_value = CFG_W'(POINTS);
        3:       cfg_value = 5'd1;
        default: cfg_value = CFG_W'($urandom_range(POINTS, 2));
      endcase
      set_points(cfg_value);
      n = active_count(cfg_value);

      // ascending maturities, occasionally tightly packed or repeated
      shuffled = ($urandom_range(7) == 0);
      t_acc    = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(24'h0F_FFFF));
      step_max = ($urandom_range(4) == 0) ? int'($urandom_range(8))
                                          : (int'(TIME_MAX) - t_acc) / n;
      for (i = 0; i < n; i++) begin
        if (i > 0) t_acc += int'($urandom_range(step_max));
        if (t_acc > int'(TIME_MAX)) t_acc = int'(TIME_MAX);
        tt[i] = shuffled ? TIME_W'($urandom()) : TIME_W'(t_acc);
        case ($urandom_range(7))
          0:       ff[i] = '0;
          1:       ff[i] = FACTOR_MAX;
          default: ff[i] = $urandom();
        endcase
        write_point(IDX_W'(i), tt[i], ff[i]);
        sent++;
      end

      lo = tt[0];
      hi = tt[n-1];
      if (lo > hi) begin
        lo = tt[n-1];
        hi = tt[0];
      end

      nq = $urandom_range(40, 8);
      for (q = 0; q < nq; q++) begin
        pick = $urandom_range(19);
        slot = $urandom_range(n - 1);
        if (pick <= 12) begin
          qt = TIME_W'($urandom_range(hi, lo));
        end else if (pick <= 14) begin
          qt = tt[slot];
        end else if (pick == 15) begin
          qt = tt[slot] + 1'b1;
        end else if (pick == 16) begin
          qt = tt[slot] - 1'b1;
        end else if (pick == 17) begin
          qt = TIME_W'($urandom());
        end else if (pick == 18) begin
          qt = $urandom_range(1) ? TIME_MAX : '0;
        end else begin
          // stray write anywhere in the table
          slot     = $urandom_range(POINTS - 1);
          tt[slot] = TIME_W'($urandom());
          ff[slot] = $urandom();
          write_point(IDX_W'(slot), tt[slot], ff[slot]);
        end
        if (pick <= 18) query_curve(qt);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 27;
    test_fill_table();
    test_curve_corners();
    test_point_count();
    test_unsorted_table();

    // sender idles at times, then often, then never
    test_random_curves(27, 510);
    test_random_curves(67, 510);
    test_random_curves(0, 510);

    // drain, then leave room for any stray result
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
